// ===== rtl/ptok_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptok_pkg: shared types and constants of the pattern tokenizer
// Payload structs, lexer state, token kind codes and character helpers.
// ----------------------------------------------------------------------------
package ptok_pkg;

  localparam int MaxTokens = 4;
  localparam int CandTokens = 6;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_COLON  = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_TEXT   = 3'd3,
    MODE_ESC    = 3'd4,
    MODE_HALT   = 3'd5
  } mode_t;

  localparam logic [4:0] KIND_START     = 5'd0;
  localparam logic [4:0] KIND_ANY       = 5'd1;
  localparam logic [4:0] KIND_CLASS_W   = 5'd2;
  localparam logic [4:0] KIND_CLASS_I   = 5'd3;
  localparam logic [4:0] KIND_CLASS_Q   = 5'd4;
  localparam logic [4:0] KIND_CLASS_Z   = 5'd5;
  localparam logic [4:0] KIND_NUMBER    = 5'd6;
  localparam logic [4:0] KIND_TEXT      = 5'd7;
  localparam logic [4:0] KIND_BACKSLASH = 5'd8;
  localparam logic [4:0] KIND_STAR      = 5'd9;
  localparam logic [4:0] KIND_LBRACKET  = 5'd10;
  localparam logic [4:0] KIND_RBRACKET  = 5'd11;
  localparam logic [4:0] KIND_LBRACE    = 5'd12;
  localparam logic [4:0] KIND_RBRACE    = 5'd13;
  localparam logic [4:0] KIND_LANGLE    = 5'd14;
  localparam logic [4:0] KIND_RANGLE    = 5'd15;
  localparam logic [4:0] KIND_LPAREN    = 5'd16;
  localparam logic [4:0] KIND_RPAREN    = 5'd17;
  localparam logic [4:0] KIND_BAR       = 5'd18;
  localparam logic [4:0] KIND_PLUS      = 5'd19;
  localparam logic [4:0] KIND_END       = 5'd20;
  localparam logic [4:0] KIND_ERROR     = 5'd21;
  localparam logic [4:0] KIND_NONE      = 5'd0;

  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_W         = 8'h77;
  localparam logic [7:0] CH_I         = 8'h69;
  localparam logic [7:0] CH_Q         = 8'h71;
  localparam logic [7:0] CH_Z         = 8'h7A;

  typedef struct packed {
    logic [7:0] pattern_char;
    logic       pattern_last;
  } char_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [31:0] number_value;
    logic [7:0]  text_char;
    logic        text_end;
    logic        result_last;
  } token_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] number_accum;
    logic [7:0]  held_text_char;
    logic        held_valid;
    logic        start_sent;
  } lex_state_t;

  typedef struct packed {
    logic [2:0]                 count;
    token_t [MaxTokens-1:0]     tokens;
  } lex_result_t;

  function automatic logic [4:0] single_kind(input logic [7:0] c);
    logic [4:0] k;
    k = KIND_NONE;
    unique case (c)
      8'h5C:   k = KIND_BACKSLASH;
      8'h2A:   k = KIND_STAR;
      8'h5B:   k = KIND_LBRACKET;
      8'h5D:   k = KIND_RBRACKET;
      8'h7B:   k = KIND_LBRACE;
      8'h7D:   k = KIND_RBRACE;
      8'h3C:   k = KIND_LANGLE;
      8'h3E:   k = KIND_RANGLE;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h7C:   k = KIND_BAR;
      8'h2B:   k = KIND_PLUS;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    return (c == CH_COLON) || (c == CH_DOT) || (single_kind(c) != KIND_NONE);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic token_t make_token(input logic [4:0] kind, input logic [31:0] num,
                                        input logic [7:0] ch, input logic tend);
    token_t t;
    t.token_kind   = kind;
    t.number_value = num;
    t.text_char    = ch;
    t.text_end     = tend;
    t.result_last  = 1'b0;
    return t;
  endfunction

endpackage

// ===== rtl/ptok_lexer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptok_lexer: single character step of the tokenizer
// Computes the tokens caused by one character and the next lexer state.
// ----------------------------------------------------------------------------
module ptok_lexer (
  input  ptok_pkg::char_t      char_in,
  input  ptok_pkg::lex_state_t state,
  output ptok_pkg::lex_state_t state_next,
  output ptok_pkg::lex_result_t result
);
  import ptok_pkg::*;

  token_t      cand [CandTokens];
  logic [2:0]  n;
  lex_state_t  s;
  logic        run_normal;
  logic [7:0]  c;
  logic [31:0] digit_val;
  logic [31:0] accum_step;

  assign c          = char_in.pattern_char;
  assign digit_val  = {24'd0, c - CH_ZERO};
  assign accum_step = (state.number_accum * 32'd10) + digit_val;

  always_comb begin
    for (int i = 0; i < CandTokens; i++) begin
      cand[i] = '0;
    end
    n          = 3'd0;
    s          = state;
    run_normal = 1'b0;

    if (!s.start_sent) begin
      cand[n] = make_token(KIND_START, 32'd0, 8'd0, 1'b0);
      n = n + 3'd1;
      s.start_sent = 1'b1;
    end

    unique case (s.mode)
      MODE_COLON: begin
        s.mode = MODE_NORMAL;
        unique case (c)
          CH_W:    cand[n] = make_token(KIND_CLASS_W, 32'd0, 8'd0, 1'b0);
          CH_I:    cand[n] = make_token(KIND_CLASS_I, 32'd0, 8'd0, 1'b0);
          CH_Q:    cand[n] = make_token(KIND_CLASS_Q, 32'd0, 8'd0, 1'b0);
          CH_Z:    cand[n] = make_token(KIND_CLASS_Z, 32'd0, 8'd0, 1'b0);
          default: begin
            cand[n] = make_token(KIND_ERROR, 32'd0, 8'd0, 1'b0);
            s.mode = MODE_HALT;
          end
        endcase
        n = n + 3'd1;
      end
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          s.number_accum = accum_step;
        end else begin
          cand[n] = make_token(KIND_NUMBER, s.number_accum, 8'd0, 1'b0);
          n = n + 3'd1;
          s.number_accum = 32'd0;
          run_normal = 1'b1;
        end
      end
      MODE_TEXT: begin
        if (c == CH_BACKSLASH) begin
          s.mode = MODE_ESC;
        end else if (is_special(c) || (c == CH_NUL)) begin
          if (s.held_valid) begin
            cand[n] = make_token(KIND_TEXT, 32'd0, s.held_text_char, 1'b1);
            n = n + 3'd1;
          end
          s.held_valid = 1'b0;
          s.held_text_char = 8'd0;
          run_normal = 1'b1;
        end else begin
          if (s.held_valid) begin
            cand[n] = make_token(KIND_TEXT, 32'd0, s.held_text_char, 1'b0);
            n = n + 3'd1;
          end
          s.held_valid = 1'b1;
          s.held_text_char = c;
        end
      end
      MODE_ESC: begin
        if (is_special(c)) begin
          if (s.held_valid) begin
            cand[n] = make_token(KIND_TEXT, 32'd0, s.held_text_char, 1'b0);
            n = n + 3'd1;
          end
          s.held_valid = 1'b1;
          s.held_text_char = c;
          s.mode = MODE_TEXT;
        end else begin
          if (s.held_valid) begin
            cand[n] = make_token(KIND_TEXT, 32'd0, s.held_text_char, 1'b1);
            n = n + 3'd1;
          end
          s.held_valid = 1'b0;
          s.held_text_char = 8'd0;
          cand[n] = make_token(KIND_BACKSLASH, 32'd0, 8'd0, 1'b0);
          n = n + 3'd1;
          run_normal = 1'b1;
        end
      end
      MODE_HALT: begin
      end
      default: begin
        run_normal = 1'b1;
      end
    endcase

    if (run_normal) begin
      s.mode = MODE_NORMAL;
      if (c == CH_DOT) begin
        cand[n] = make_token(KIND_ANY, 32'd0, 8'd0, 1'b0);
        n = n + 3'd1;
      end else if (c == CH_COLON) begin
        s.mode = MODE_COLON;
      end else if (is_digit(c)) begin
        s.number_accum = digit_val;
        s.mode = MODE_NUMBER;
      end else if (c == CH_BACKSLASH) begin
        s.held_valid = 1'b0;
        s.mode = MODE_ESC;
      end else if (single_kind(c) != KIND_NONE) begin
        cand[n] = make_token(single_kind(c), 32'd0, 8'd0, 1'b0);
        n = n + 3'd1;
      end else if (c == CH_NUL) begin
        cand[n] = make_token(KIND_ERROR, 32'd0, 8'd0, 1'b0);
        n = n + 3'd1;
        s.mode = MODE_HALT;
      end else begin
        s.held_text_char = c;
        s.held_valid = 1'b1;
        s.mode = MODE_TEXT;
      end
    end

    if (char_in.pattern_last) begin
      unique case (s.mode)
        MODE_NUMBER: begin
          cand[n] = make_token(KIND_NUMBER, s.number_accum, 8'd0, 1'b0);
          n = n + 3'd1;
        end
        MODE_TEXT: begin
          if (s.held_valid) begin
            cand[n] = make_token(KIND_TEXT, 32'd0, s.held_text_char, 1'b1);
            n = n + 3'd1;
          end
        end
        MODE_ESC: begin
          if (s.held_valid) begin
            cand[n] = make_token(KIND_TEXT, 32'd0, s.held_text_char, 1'b1);
            n = n + 3'd1;
          end
          cand[n] = make_token(KIND_BACKSLASH, 32'd0, 8'd0, 1'b0);
          n = n + 3'd1;
        end
        MODE_COLON: begin
          cand[n] = make_token(KIND_ERROR, 32'd0, 8'd0, 1'b0);
          n = n + 3'd1;
        end
        default: begin
        end
      endcase
      cand[n] = make_token(KIND_END, 32'd0, 8'd0, 1'b0);
      n = n + 3'd1;
      s = '0;
      s.mode = MODE_NORMAL;
    end
  end

  always_comb begin
    result.count = (n > 3'd4) ? 3'd4 : n;
    for (int i = 0; i < MaxTokens; i++) begin
      result.tokens[i] = cand[i];
      result.tokens[i].result_last = (result.count == 3'(i + 1));
    end
  end

  assign state_next = s;

endmodule

// ===== rtl/pattern_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pattern_tokenizer: find-pattern tokenizer, one character per transfer
// Splits a character stream into start, any, class, number, text, special,
// error and end tokens, delivered one token per output transfer.
// ----------------------------------------------------------------------------
// The first token of a character is offered in the cycle after its
// transfer. A character yields at most four tokens, which leave through the
// single token output port; the next character is taken in the cycle its
// last token is transferred. Reset clears the lexer state and empties the
// token buffer.
module pattern_tokenizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_ready,
  input  ptok_pkg::char_t    char_data,
  output logic               token_valid,
  input  logic               token_ready,
  output ptok_pkg::token_t   token_data
);
  import ptok_pkg::*;

  lex_state_t  state;
  lex_state_t  state_next;
  lex_result_t lex_res;
  token_t      buffer [MaxTokens];
  logic [2:0]  remaining;
  logic [1:0]  rd_ptr;
  logic        char_xfer;
  logic        token_xfer;

  ptok_lexer u_lexer (
    .char_in    (char_data),
    .state      (state),
    .state_next (state_next),
    .result     (lex_res)
  );

  assign token_valid = (remaining != 3'd0);
  assign token_data  = buffer[rd_ptr];
  assign token_xfer  = token_valid && token_ready;
  assign char_ready  = (remaining == 3'd0) || ((remaining == 3'd1) && token_ready);
  assign char_xfer   = char_valid && char_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      remaining <= 3'd0;
      rd_ptr    <= 2'd0;
    end else if (char_xfer) begin
      state     <= state_next;
      remaining <= lex_res.count;
      rd_ptr    <= 2'd0;
    end else if (token_xfer) begin
      remaining <= remaining - 3'd1;
      rd_ptr    <= rd_ptr + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (char_xfer) begin
      for (int i = 0; i < MaxTokens; i++) begin
        buffer[i] <= lex_res.tokens[i];
      end
    end
  end

`ifndef SYNTHESIS
  a_tokens_follow: assert property (@(posedge clk) disable iff (rst)
    (char_xfer && (lex_res.count != 3'd0)) |=> token_valid)
    else $error("tokens of a transferred character are not offered");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> (token_data.result_last == (remaining == 3'd1)))
    else $error("result_last does not match the buffered token count");

  a_buffer_bound: assert property (@(posedge clk) disable iff (rst)
    token_valid |-> ((3'(rd_ptr) + remaining) <= 3'd4))
    else $error("token buffer read past its end");

  a_pattern_close: assert property (@(posedge clk) disable iff (rst)
    (char_xfer && char_data.pattern_last) |=>
      ((state.mode == MODE_NORMAL) && !state.start_sent && !state.held_valid))
    else $error("lexer state not cleared after the final character");

  a_start_first: assert property (@(posedge clk) disable iff (rst)
    (token_valid && (token_data.token_kind == KIND_START)) |-> (rd_ptr == 2'd0))
    else $error("start token not first for its character");
`endif

endmodule
